@@ rtl/ppps_pkg.sv @@
// Package for the particle pool physics step block.
// Holds the particle record type, fixed-point constants and the sat32 saturation helper; no dependencies.
`timescale 1ns / 1ps

package ppps_pkg;

  localparam int unsigned GRAVITY_Q8   = 204800;
  localparam int unsigned FRICTION_Q16 = 52429;

  localparam logic FUNC_EMIT = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [23:0]        life;
    logic [15:0]        color;
  } particle_t;

  // Saturates a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ rtl/ppps_if.sv @@
// Valid/ready channel interfaces for the particle pool block.
// Does not depend on ppps_pkg; payloads are plain vectors.
`timescale 1ns / 1ps

interface ppps_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic signed [31:0] in_vel_x;
  logic signed [31:0] in_vel_y;
  logic signed [31:0] in_vel_z;
  logic [23:0]        in_life;
  logic [15:0]        in_color;
  logic [15:0]        time_step;
  modport source (output valid, func, in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y,
                  in_vel_z, in_life, in_color, time_step, input ready);
  modport sink (input valid, func, in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y,
                in_vel_z, in_life, in_color, time_step, output ready);
endinterface

interface ppps_out_if;
  logic               valid;
  logic               ready;
  logic               entry_valid;
  logic               accepted;
  logic [6:0]         active_count;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [31:0] out_vel_z;
  logic [23:0]        life_left;
  logic [15:0]        out_color;
  logic               last_of_run;
  modport source (output valid, entry_valid, accepted, active_count, out_pos_x, out_pos_y,
                  out_pos_z, out_vel_x, out_vel_y, out_vel_z, life_left, out_color,
                  last_of_run, input ready);
  modport sink (input valid, entry_valid, accepted, active_count, out_pos_x, out_pos_y,
                out_pos_z, out_vel_x, out_vel_y, out_vel_z, life_left, out_color,
                last_of_run, output ready);
endinterface

@@ rtl/particle_pool_physics_step.sv @@
// Particle pool physics step: emit a particle or integrate and stream the pool.
// Emit, or a tick on an empty pool: the single result is offered the cycle after the transfer.
// Tick: entries are checked from the top down; live ones are integrated and written back,
// expired ones replaced by the last; then live entries stream out, or one result if none live.
// Only one item is in work at a time; in_ready is high only when idle.
// Synchronous active-low reset clears the count and the sequencer; memory is not cleared.
`timescale 1ns / 1ps

module particle_pool_physics_step #(
  parameter int POOL_SIZE = 64
) (
  input  logic clk,
  input  logic rst_n,
  ppps_in_if.sink    in_ch,
  ppps_out_if.source out_ch
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_M3    = 4'd5;
  localparam logic [3:0] S_M4    = 4'd6;
  localparam logic [3:0] S_FX    = 4'd7;
  localparam logic [3:0] S_FY    = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_CPRD  = 4'd10;
  localparam logic [3:0] S_CPWR  = 4'd11;
  localparam logic [3:0] S_ORD   = 4'd12;
  localparam logic [3:0] S_OLAT  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  ppps_pkg::particle_t mem [POOL_SIZE];
  ppps_pkg::particle_t rd_r;
  ppps_pkg::particle_t p_r, p_nxt;

  logic [3:0]    st_r, st_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [6:0]    idx_r, idx_nxt;
  logic [15:0]   dt_r, dt_nxt;
  logic          acc_r, acc_nxt;
  logic          ov_r, ov_nxt;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  ppps_pkg::particle_t wr_data;

  logic signed [31:0] mul_a;
  logic [16:0]        mul_f;
  logic signed [33:0] mul_q;

  logic signed [33:0] sum34;
  logic signed [33:0] negh;

  ppps_mul u_mul (.clk(clk), .a(mul_a), .f(mul_f), .q_r(mul_q));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    dt_nxt     = dt_r;
    acc_nxt    = acc_r;
    ov_nxt     = ov_r;
    p_nxt      = p_r;
    rd_addr    = idx_r[AW-1:0];
    wr_addr    = idx_r[AW-1:0];
    wr_en      = 1'b0;
    wr_data    = p_r;
    mul_a      = p_r.vel_x;
    mul_f      = {1'b0, dt_r};
    sum34      = '0;
    negh       = '0;
    in_ch.ready = (st_r == S_IDLE);
    out_ch.valid = (st_r == S_OUT) || (st_r == S_DONE);

    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          dt_nxt = in_ch.time_step;
          if (in_ch.func == ppps_pkg::FUNC_EMIT) begin
            acc_nxt = 1'b0;
            if (cnt_r < 7'(POOL_SIZE)) begin
              wr_en   = 1'b1;
              wr_addr = cnt_r[AW-1:0];
              wr_data = '{in_ch.in_pos_x, in_ch.in_pos_y, in_ch.in_pos_z, in_ch.in_vel_x,
                          in_ch.in_vel_y, in_ch.in_vel_z, in_ch.in_life, in_ch.in_color};
              cnt_nxt = cnt_r + 7'd1;
              acc_nxt = 1'b1;
            end
            st_nxt = S_DONE;
          end else begin
            acc_nxt = 1'b0;
            if (cnt_r == 7'd0) begin
              st_nxt = S_DONE;
            end else begin
              idx_nxt = cnt_r - 7'd1;
              st_nxt  = S_RD;
            end
          end
        end
      end
      S_RD: begin
        st_nxt = S_CHK;
      end
      S_CHK: begin
        p_nxt = rd_r;
        if (rd_r.life <= {8'd0, dt_r}) begin
          cnt_nxt = cnt_r - 7'd1;
          if (idx_r == cnt_r - 7'd1) begin
            st_nxt = S_CPWR;
            ov_nxt = 1'b0;
          end else begin
            st_nxt = S_CPRD;
          end
        end else begin
          p_nxt.life = rd_r.life - {8'd0, dt_r};
          mul_a  = rd_r.vel_x;
          st_nxt = S_M1;
        end
      end
      S_M1: begin
        sum34 = 34'(p_r.pos_x) + mul_q;
        p_nxt.pos_x = ppps_pkg::sat32(sum34);
        mul_a  = p_r.vel_y;
        st_nxt = S_M2;
      end
      S_M2: begin
        sum34 = 34'(p_r.pos_y) + mul_q;
        p_nxt.pos_y = ppps_pkg::sat32(sum34);
        mul_a  = p_r.vel_z;
        st_nxt = S_M3;
      end
      S_M3: begin
        sum34 = 34'(p_r.pos_z) + mul_q;
        p_nxt.pos_z = ppps_pkg::sat32(sum34);
        mul_a  = 32'(ppps_pkg::GRAVITY_Q8);
        st_nxt = S_M4;
      end
      S_M4: begin
        sum34 = 34'(p_r.vel_z) - mul_q;
        p_nxt.vel_z = ppps_pkg::sat32(sum34);
        if (p_r.pos_z[31]) begin
          p_nxt.pos_z = '0;
          negh = (-34'(ppps_pkg::sat32(sum34)) + 34'sd1) >>> 1;
          p_nxt.vel_z = ppps_pkg::sat32(negh);
          mul_a  = p_r.vel_x;
          mul_f  = 17'(ppps_pkg::FRICTION_Q16);
          st_nxt = S_FX;
        end else begin
          st_nxt = S_WR;
        end
      end
      S_FX: begin
        p_nxt.vel_x = ppps_pkg::sat32(mul_q);
        mul_a  = p_r.vel_y;
        mul_f  = 17'(ppps_pkg::FRICTION_Q16);
        st_nxt = S_FY;
      end
      S_FY: begin
        p_nxt.vel_y = ppps_pkg::sat32(mul_q);
        st_nxt = S_WR;
      end
      S_WR: begin
        wr_en = 1'b1;
        st_nxt = S_CPWR;
        ov_nxt = 1'b0;
        if (idx_r == 7'd0) begin
          st_nxt = S_ORD;
        end else begin
          idx_nxt = idx_r - 7'd1;
          st_nxt  = S_RD;
        end
      end
      S_CPRD: begin
        rd_addr = cnt_r[AW-1:0];
        ov_nxt  = 1'b1;
        st_nxt  = S_CPWR;
      end
      S_CPWR: begin
        if (ov_r) begin
          wr_en   = 1'b1;
          wr_data = rd_r;
        end
        ov_nxt = 1'b0;
        if (idx_r == 7'd0) begin
          st_nxt = S_ORD;
        end else begin
          idx_nxt = idx_r - 7'd1;
          st_nxt  = S_RD;
        end
      end
      S_ORD: begin
        if (cnt_r == 7'd0) begin
          st_nxt = S_DONE;
        end else begin
          idx_nxt = 7'd0;
          rd_addr = '0;
          st_nxt  = S_OLAT;
        end
      end
      S_OLAT: begin
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (idx_r == cnt_r - 7'd1) begin
            st_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 7'd1;
            rd_addr = idx_nxt[AW-1:0];
            st_nxt  = S_OLAT;
          end
        end else begin
          rd_addr = idx_r[AW-1:0];
        end
      end
      S_DONE: begin
        if (out_ch.ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    idx_r    <= idx_nxt;
    dt_r     <= dt_nxt;
    acc_r    <= acc_nxt;
    p_r      <= p_nxt;
  end

  logic show;
  assign show = (st_r == S_OUT);

  assign out_ch.entry_valid  = show;
  assign out_ch.accepted     = (st_r == S_DONE) && acc_r;
  assign out_ch.active_count = cnt_r;
  assign out_ch.out_pos_x    = show ? rd_r.pos_x : '0;
  assign out_ch.out_pos_y    = show ? rd_r.pos_y : '0;
  assign out_ch.out_pos_z    = show ? rd_r.pos_z : '0;
  assign out_ch.out_vel_x    = show ? rd_r.vel_x : '0;
  assign out_ch.out_vel_y    = show ? rd_r.vel_y : '0;
  assign out_ch.out_vel_z    = show ? rd_r.vel_z : '0;
  assign out_ch.life_left    = show ? rd_r.life : '0;
  assign out_ch.out_color    = show ? rd_r.color : '0;
  assign out_ch.last_of_run  = (st_r == S_DONE) || (idx_r == cnt_r - 7'd1);

endmodule

@@ rtl/ppps_mul.sv @@
// Shared signed 32 x unsigned 17 multiplier with Q16 rounding, one registered result a cycle.
// Does not depend on ppps_pkg.
`timescale 1ns / 1ps

module ppps_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic [16:0]        f,
  output logic signed [33:0] q_r
);

  logic signed [49:0] prod;
  logic signed [49:0] biased;

  assign prod   = 50'(a) * $signed({33'd0, f});
  assign biased = prod + 50'sd32768;

  always_ff @(posedge clk) begin
    q_r <= biased[49:16];
  end

endmodule

@@ bench/particle_pool_physics_step_tb.sv @@
// Testbench for the particle pool physics step block: emits and ticks with randomised handshakes.
// Depends on ppps_pkg and the ppps_in_if / ppps_out_if interfaces; checks every transfer
// against a fixed-point pool predictor kept inside this file.
`timescale 1ns / 1ps

module particle_pool_physics_step_tb;

  localparam int POOL = 64;

  typedef struct packed {
    logic               func;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [23:0]        life;
    logic [15:0]        color;
    logic [15:0]        dt;
  } request_t;

  typedef struct packed {
    logic                entry_valid;
    logic                accepted;
    logic [6:0]          count;
    ppps_pkg::particle_t part;
    logic                last;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ppps_in_if  in_ch();
  ppps_out_if out_ch();

  particle_pool_physics_step #(.POOL_SIZE(POOL)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  request_t            pending_items[$];
  status_t             expected_results[$];
  ppps_pkg::particle_t pool_model[POOL];
  int        pool_live;
  int        fail_count;
  int        result_count;
  int        tick_count;
  int        bounce_count;
  int        expire_count;
  int        reject_count;
  int        max_live;
  int        send_gap;
  int        recv_gap;
  bit        sending;
  bit        in_fired;
  bit        out_fired;

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] p, input int s);
    logic signed [63:0] b;
    b = p + (64'sd1 <<< (s - 1));
    return b >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] scale_q16(input logic signed [31:0] a,
                                                   input logic [15:0] f);
    logic signed [63:0] prod;
    prod = 64'(a) * $signed({48'd0, f});
    return round_shift(prod, 16);
  endfunction

  task automatic predict_pool(input request_t r);
    status_t             s;
    ppps_pkg::particle_t p;
    logic signed [63:0]  grav;
    s = '0;
    if (r.func == ppps_pkg::FUNC_EMIT) begin
      if (pool_live < POOL) begin
        p.pos_x = r.px; p.pos_y = r.py; p.pos_z = r.pz;
        p.vel_x = r.vx; p.vel_y = r.vy; p.vel_z = r.vz;
        p.life = r.life; p.color = r.color;
        pool_model[pool_live] = p;
        pool_live++;
        s.accepted = 1'b1;
      end else begin
        reject_count++;
      end
      if (pool_live > max_live) max_live = pool_live;
      s.count = 7'(pool_live);
      s.last = 1'b1;
      expected_results.push_back(s);
      return;
    end
    tick_count++;
    grav = round_shift(64'sd204800 * $signed({48'd0, r.dt}), 16);
    for (int i = pool_live - 1; i >= 0; i--) begin
      p = pool_model[i];
      if (p.life <= {8'd0, r.dt}) begin
        pool_live--;
        expire_count++;
        pool_model[i] = pool_model[pool_live];
        continue;
      end
      p.life = p.life - {8'd0, r.dt};
      p.pos_x = clamp32(64'(p.pos_x) + scale_q16(p.vel_x, r.dt));
      p.pos_y = clamp32(64'(p.pos_y) + scale_q16(p.vel_y, r.dt));
      p.pos_z = clamp32(64'(p.pos_z) + scale_q16(p.vel_z, r.dt));
      p.vel_z = clamp32(64'(p.vel_z) - grav);
      if (p.pos_z < 0) begin
        bounce_count++;
        p.pos_z = '0;
        p.vel_z = clamp32(round_shift(-64'(p.vel_z), 1));
        p.vel_x = clamp32(scale_q16(p.vel_x, 16'(ppps_pkg::FRICTION_Q16)));
        p.vel_y = clamp32(scale_q16(p.vel_y, 16'(ppps_pkg::FRICTION_Q16)));
      end
      pool_model[i] = p;
    end
    if (pool_live == 0) begin
      s.last = 1'b1;
      expected_results.push_back(s);
      return;
    end
    for (int i = 0; i < pool_live; i++) begin
      s = '0;
      s.entry_valid = 1'b1;
      s.count = 7'(pool_live);
      s.part = pool_model[i];
      s.last = (i == pool_live - 1);
      expected_results.push_back(s);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic request_t make_emit(input int style);
    request_t r;
    r = '0;
    r.func = ppps_pkg::FUNC_EMIT;
    r.px = $urandom(); r.py = $urandom();
    r.vx = $signed($urandom_range(0, 40000)) - 20000;
    r.vy = $signed($urandom_range(0, 40000)) - 20000;
    r.pz = $urandom_range(0, 100000);
    r.vz = $signed($urandom_range(0, 200000)) - 100000;
    r.life = 24'($urandom_range(1000, 400000));
    r.color = 16'($urandom());
    if (style == 1) begin
      r.pz = $urandom(); r.vx = $urandom(); r.vy = $urandom(); r.vz = $urandom();
      r.life = 24'($urandom());
    end
    return r;
  endfunction

  function automatic request_t make_tick(input logic [15:0] dt);
    request_t r;
    r = '0;
    r.func = ppps_pkg::FUNC_TICK;
    r.dt = dt;
    r.px = $urandom(); r.life = 24'($urandom());
    return r;
  endfunction

  // Driver: the current item is held on the channel until it transfers.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      sending = 1'b0;
      in_fired = 1'b0;
    end else if (in_fired) begin
      // Transfer took place at the last rising edge.
      in_fired = 1'b0;
      sending = 1'b0;
      send_gap = $urandom_range(0, 4);
      if (send_gap == 0 && pending_items.size() > 0) begin
        sending = 1'b1;
        drive_item(pending_items.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end else if (!sending) begin
      if (send_gap > 0) begin
        send_gap--;
      end
      if (send_gap == 0 && pending_items.size() > 0) begin
        sending = 1'b1;
        drive_item(pending_items.pop_front());
      end
    end
  end

  task automatic drive_item(input request_t r);
    in_ch.valid     <= 1'b1;
    in_ch.func      <= r.func;
    in_ch.in_pos_x  <= r.px;
    in_ch.in_pos_y  <= r.py;
    in_ch.in_pos_z  <= r.pz;
    in_ch.in_vel_x  <= r.vx;
    in_ch.in_vel_y  <= r.vy;
    in_ch.in_vel_z  <= r.vz;
    in_ch.in_life   <= r.life;
    in_ch.in_color  <= r.color;
    in_ch.time_step <= r.dt;
  endtask

  // Prediction happens on the accepting edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      request_t r;
      r.func = in_ch.func;
      r.px = in_ch.in_pos_x; r.py = in_ch.in_pos_y; r.pz = in_ch.in_pos_z;
      r.vx = in_ch.in_vel_x; r.vy = in_ch.in_vel_y; r.vz = in_ch.in_vel_z;
      r.life = in_ch.in_life; r.color = in_ch.in_color; r.dt = in_ch.time_step;
      in_fired = 1'b1;
      predict_pool(r);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
      out_fired = 1'b0;
    end else if (out_fired) begin
      out_fired = 1'b0;
      recv_gap = $urandom_range(0, 4);
      out_ch.ready <= (recv_gap == 0);
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= (recv_gap == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      status_t w;
      out_fired = 1'b1;
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = expected_results.pop_front();
        if (out_ch.entry_valid !== w.entry_valid)
          report_mismatch("entry_valid", out_ch.entry_valid, w.entry_valid);
        if (out_ch.accepted !== w.accepted)
          report_mismatch("accepted", out_ch.accepted, w.accepted);
        if (out_ch.active_count !== w.count)
          report_mismatch("active_count", out_ch.active_count, w.count);
        if (out_ch.out_pos_x !== w.part.pos_x)
          report_mismatch("out_pos_x", out_ch.out_pos_x, w.part.pos_x);
        if (out_ch.out_pos_y !== w.part.pos_y)
          report_mismatch("out_pos_y", out_ch.out_pos_y, w.part.pos_y);
        if (out_ch.out_pos_z !== w.part.pos_z)
          report_mismatch("out_pos_z", out_ch.out_pos_z, w.part.pos_z);
        if (out_ch.out_vel_x !== w.part.vel_x)
          report_mismatch("out_vel_x", out_ch.out_vel_x, w.part.vel_x);
        if (out_ch.out_vel_y !== w.part.vel_y)
          report_mismatch("out_vel_y", out_ch.out_vel_y, w.part.vel_y);
        if (out_ch.out_vel_z !== w.part.vel_z)
          report_mismatch("out_vel_z", out_ch.out_vel_z, w.part.vel_z);
        if (out_ch.life_left !== w.part.life)
          report_mismatch("life_left", out_ch.life_left, w.part.life);
        if (out_ch.out_color !== w.part.color)
          report_mismatch("out_color", out_ch.out_color, w.part.color);
        if (out_ch.last_of_run !== w.last)
          report_mismatch("last_of_run", out_ch.last_of_run, w.last);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    request_t r;
    int       n;
    pool_live = 0; fail_count = 0; result_count = 0; tick_count = 0;
    bounce_count = 0; expire_count = 0; reject_count = 0; max_live = 0;
    send_gap = 0; recv_gap = 0; sending = 1'b0; in_fired = 1'b0; out_fired = 1'b0;
    in_ch.valid = 1'b0; in_ch.func = ppps_pkg::FUNC_EMIT;
    in_ch.in_pos_x = '0; in_ch.in_pos_y = '0; in_ch.in_pos_z = '0;
    in_ch.in_vel_x = '0; in_ch.in_vel_y = '0; in_ch.in_vel_z = '0;
    in_ch.in_life = '0; in_ch.in_color = '0; in_ch.time_step = '0;
    out_ch.ready = 1'b0;

    // Directed part: empty tick, extremes, saturation, bounce, expiry.
    pending_items.push_back(make_tick(16'd1000));
    r = make_emit(0);
    r.px = 32'sh7FFF_FFFF; r.vx = 32'sh7FFF_FFFF; r.py = 32'sh8000_0000;
    r.vy = 32'sh8000_0000; r.pz = 32'sh7FFF_FFFF; r.vz = 32'sh7FFF_FFFF;
    r.life = 24'hFF_FFFF; r.color = 16'hFFFF;
    pending_items.push_back(r);
    r = make_emit(0);
    r.pz = 32'sh8000_0000; r.vz = 32'sh8000_0000; r.vx = 32'sh8000_0000;
    r.vy = 32'sh7FFF_FFFF; r.life = 24'h80_0000; r.color = 16'h0000;
    pending_items.push_back(r);
    r = make_emit(0); r.pz = 10; r.vz = -5000; r.life = 24'hFFFF;
    pending_items.push_back(r);
    r = make_emit(0); r.life = 24'd100;
    pending_items.push_back(r);
    r = make_emit(0); r.life = 24'd0;
    pending_items.push_back(r);
    pending_items.push_back(make_tick(16'hFFFF));
    pending_items.push_back(make_tick(16'd0));
    pending_items.push_back(make_tick(16'd100));
    pending_items.push_back(make_tick(16'd1));
    // Fill the pool past capacity so that emits are refused.
    for (int i = 0; i < POOL + 2; i++) pending_items.push_back(make_emit(i % 8 == 0));
    pending_items.push_back(make_tick(16'd2000));
    // Drain by ticking with large steps.
    for (int i = 0; i < 12; i++) pending_items.push_back(make_tick(16'hFFFF));
    pending_items.push_back(make_tick(16'h8000));

    // Random part: emits and ticks in random order, emits twice as likely as ticks.
    n = 0;
    while (n < 60) begin
      if ($urandom_range(0, 2) == 0) begin
        pending_items.push_back(make_tick($urandom_range(0, 3) == 0 ?
                                          16'($urandom()) : 16'($urandom_range(0, 3000))));
      end else begin
        pending_items.push_back(make_emit($urandom_range(0, 9) == 0));
      end
      n++;
    end
    pending_items.push_back(make_tick(16'hFFFF));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_items.size() == 0 && !sending);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);

    $display("Covered %0d results over %0d ticks, peak pool %0d, %0d refused emits,",
             result_count, tick_count, max_live, reject_count);
    $display("%0d expiries and %0d floor bounces.", expire_count, bounce_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ppps_pkg.sv
rtl/ppps_if.sv
rtl/ppps_mul.sv
rtl/particle_pool_physics_step.sv
bench/particle_pool_physics_step_tb.sv
